@@ rtl/core/macd_pkg.sv @@
// shared types, constants and microcode program of the moving average change detector
`timescale 1ns / 1ps

package macd_pkg;

    // sample and average field width
    localparam int unsigned AXIS_W   = 16;
    localparam int unsigned NUM_AXES = 3;
    localparam int unsigned STEP_W   = 4;

    // threshold after reset: 0.5 m/s^2 in raw counts at 16384 counts per g
    localparam logic [AXIS_W-1:0] THRESH_RESET = 16'd835;

    // axis selectors
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // condition that holds the sequencer on its current step
    typedef enum logic [1:0] {
        W_NONE = 2'd0,
        W_IN   = 2'd1,
        W_DIV  = 2'd2,
        W_OUT  = 2'd3
    } t_wait;

    // one control word
    typedef struct packed {
        t_wait             wait_on;
        logic              accept;
        logic              update;
        logic              div_start;
        logic              store;
        logic [1:0]        axis;
        logic              emit;
        logic              jump;
        logic [STEP_W-1:0] target;
    } t_uop;

    // program steps
    localparam logic [STEP_W-1:0] S_TAKE  = 4'd0;
    localparam logic [STEP_W-1:0] S_UPD   = 4'd1;
    localparam logic [STEP_W-1:0] S_DIVX  = 4'd2;
    localparam logic [STEP_W-1:0] S_STX   = 4'd3;
    localparam logic [STEP_W-1:0] S_DIVY  = 4'd4;
    localparam logic [STEP_W-1:0] S_STY   = 4'd5;
    localparam logic [STEP_W-1:0] S_DIVZ  = 4'd6;
    localparam logic [STEP_W-1:0] S_STZ   = 4'd7;
    localparam logic [STEP_W-1:0] S_EMIT  = 4'd8;

    // microcode rom
    function automatic t_uop macd_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{wait_on: W_NONE, accept: 1'b0, update: 1'b0, div_start: 1'b0,
              store: 1'b0, axis: AX_X, emit: 1'b0, jump: 1'b0, target: S_TAKE};
        case (step)
            S_TAKE: begin
                u.wait_on = W_IN;
                u.accept  = 1'b1;
            end
            S_UPD: begin
                u.update = 1'b1;
            end
            S_DIVX: begin
                u.div_start = 1'b1;
                u.axis      = AX_X;
            end
            S_STX: begin
                u.wait_on = W_DIV;
                u.store   = 1'b1;
                u.axis    = AX_X;
            end
            S_DIVY: begin
                u.div_start = 1'b1;
                u.axis      = AX_Y;
            end
            S_STY: begin
                u.wait_on = W_DIV;
                u.store   = 1'b1;
                u.axis    = AX_Y;
            end
            S_DIVZ: begin
                u.div_start = 1'b1;
                u.axis      = AX_Z;
            end
            S_STZ: begin
                u.wait_on = W_DIV;
                u.store   = 1'b1;
                u.axis    = AX_Z;
            end
            S_EMIT: begin
                u.wait_on = W_OUT;
                u.emit    = 1'b1;
                u.jump    = 1'b1;
                u.target  = S_TAKE;
            end
            default: begin
                u.jump   = 1'b1;
                u.target = S_TAKE;
            end
        endcase
        return u;
    endfunction

endpackage

@@ rtl/core/moving_average_change_detector.sv @@
// top level: sample ring, running sums, microcoded sequencer and output register
`timescale 1ns / 1ps

// Moving average change detector. Each input item carries one three-axis signed
// 16-bit sample; the block keeps the last WINDOW samples in a ring, divides each
// axis running sum by the number of samples held (up to WINDOW), truncating
// toward zero, and returns one result item per input item with the three
// averages and a flag that is set when any average moved by at least the
// programmed threshold since the previous item. Items are handled one at a time:
// the next item is taken in the cycle after the result is registered at the
// earliest, and the pace is set by the single bit-serial divider that the
// microcode runs once per axis. A new item is taken as soon as the sequencer is
// back at its first step, while the previous result may still wait in the output
// register; a result still waiting when the next one is done holds the sequencer.
// The threshold register may be written at any time the block is idle;
// o_cfg_ready is high whenever reset is released.
module moving_average_change_detector #(
    parameter int unsigned WINDOW = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // threshold write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // sample items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // sample_x, sample_y, sample_z
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // avg_x, avg_y, avg_z, change_seen, zero pad
);

    import macd_pkg::*;

    localparam int unsigned LOG_W  = $clog2(WINDOW);
    localparam int unsigned SUM_W  = AXIS_W + 1 + LOG_W;
    localparam int unsigned MAG_W  = AXIS_W + LOG_W;
    localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
    localparam int unsigned SLOT_W = (WINDOW > 1) ? LOG_W : 1;

    // sequencer
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uop              uop;
    logic              stall;
    logic              go;

    // datapath state
    logic [3*AXIS_W-1:0]       r_ring [WINDOW];
    logic [3*AXIS_W-1:0]       r_old;
    logic [3*AXIS_W-1:0]       r_in;
    logic [SLOT_W-1:0]         r_slot;
    logic [CNT_W-1:0]          r_fill;
    logic signed [SUM_W-1:0]   r_sum  [NUM_AXES];
    logic signed [AXIS_W-1:0]  r_prev [NUM_AXES];
    logic signed [AXIS_W-1:0]  r_avg  [NUM_AXES];
    logic                      r_change;
    logic                      r_neg;
    logic [AXIS_W-1:0]         r_thresh;
    logic                      r_out_valid;
    logic [55:0]               r_out_data;

    // divider hookup
    logic signed [SUM_W-1:0]   sel_sum;
    logic [SUM_W-1:0]          sum_mag;
    logic                      div_busy;
    logic [MAG_W-1:0]          div_quot;
    logic [MAG_W:0]            quot_ext;
    logic signed [AXIS_W-1:0]  new_avg;
    logic signed [AXIS_W:0]    avg_diff;
    logic [AXIS_W:0]           diff_mag;
    logic                      ring_full;

    // control word and hold condition
    always_comb begin
        uop = macd_rom(r_step);
        case (uop.wait_on)
            W_NONE:  stall = 1'b0;
            W_IN:    stall = !s_axis_tvalid;
            W_DIV:   stall = div_busy;
            W_OUT:   stall = r_out_valid;
            default: stall = 1'b0;
        endcase
        go = !stall;
        if (stall) begin
            n_step = r_step;
        end else if (uop.jump) begin
            n_step = uop.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_TAKE;
        end else begin
            r_step <= n_step;
        end
    end

    // no item is taken while reset is held
    assign s_axis_tready = uop.accept && i_rst_n;

    // threshold register
    assign o_cfg_ready = i_rst_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (go && uop.accept) begin
            r_in <= s_axis_tdata;
        end
    end

    // sample ring: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        r_old <= r_ring[r_slot];
        if (go && uop.update) begin
            r_ring[r_slot] <= r_in;
        end
    end

    assign ring_full = r_fill == CNT_W'(WINDOW);

    // ring pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fill <= '0;
        end else if (go && uop.update) begin
            r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
            if (!ring_full) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // running sums: the overwritten sample leaves once the ring is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_sum[k] <= '0;
            end
        end else if (go && uop.update) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_sum[k] <= r_sum[k]
                    - (ring_full ? SUM_W'(signed'(r_old[k*AXIS_W +: AXIS_W])) : '0)
                    + SUM_W'(signed'(r_in[k*AXIS_W +: AXIS_W]));
            end
        end
    end

    // divide the magnitude, restore the sign afterwards
    assign sel_sum = r_sum[uop.axis];
    assign sum_mag = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);

    always_ff @(posedge i_clk) begin
        if (go && uop.div_start) begin
            r_neg <= sel_sum[SUM_W-1];
        end
    end

    macd_div #(
        .DIVIDEND_W (MAG_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (go && uop.div_start),
        .i_dividend (sum_mag[MAG_W-1:0]),
        .i_divisor  (r_fill),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    // signed average and its distance from the previous one
    assign quot_ext = {1'b0, div_quot};
    assign new_avg  = r_neg ? AXIS_W'(-quot_ext) : AXIS_W'(quot_ext);
    assign avg_diff = (AXIS_W+1)'(new_avg) - (AXIS_W+1)'(r_prev[uop.axis]);
    assign diff_mag = avg_diff[AXIS_W] ? (AXIS_W+1)'(-avg_diff) : (AXIS_W+1)'(avg_diff);

    // previous averages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_prev[k] <= '0;
            end
        end else if (go && uop.store) begin
            r_prev[uop.axis] <= new_avg;
        end
    end

    // averages and change flag of the item at work
    always_ff @(posedge i_clk) begin
        if (go && uop.accept) begin
            r_change <= 1'b0;
        end else if (go && uop.store) begin
            r_avg[uop.axis] <= new_avg;
            if (diff_mag[AXIS_W-1:0] >= r_thresh) begin
                r_change <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && uop.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && uop.emit) begin
            r_out_data <= {7'b0, r_change, r_avg[AX_Z], r_avg[AX_Y], r_avg[AX_X]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ rtl/core/macd_div.sv @@
// bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle
`timescale 1ns / 1ps

module macd_div #(
    parameter int unsigned DIVIDEND_W = 20,
    parameter int unsigned DIVISOR_W  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic [DIVIDEND_W-1:0] o_quot
);

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIVIDEND_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
            r_rem <= fits ? DIVISOR_W'(trial - {1'b0, r_dvs}) : trial[DIVISOR_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quo;

endmodule
